[hw/rtl/srma_pkg.sv]
package srma_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CELL_W   = ROW_W + COL_W;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int FILL_W   = COL_W + 1;
	localparam int CFG_W    = 7;
	localparam int VAL_W    = 64;

	// command codes; the spare code decodes as a read
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BOUNDS  = 2'd1;
	localparam logic [1:0] STATUS_UNSIZED = 2'd2;

	// configuration register indexes
	localparam logic CFG_ROW_COUNT    = 1'b0;
	localparam logic CFG_COLUMN_COUNT = 1'b1;

	// default quiet NaN for an invalid add
	localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;

	// classified item between front and back
	typedef struct packed {
		logic [1:0]       cmd;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             direct;
		logic [1:0]       status;
	} srma_item_t;

	// control from back to front
	typedef struct packed {
		logic pop;
		logic clearing;
	} srma_ctl_t;

endpackage

[hw/rtl/srma_ram.sv]
module srma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/srma_fadd.sv]
module srma_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] sum
);

	typedef enum logic [2:0] {
		FS_IDLE, FS_ALIGN, FS_SUM, FS_NORM, FS_ROUND, FS_DONE
	} fstate_t;

	localparam logic [63:0] QNAN_VAL = srma_pkg::QNAN_DEFAULT;

	fstate_t     state_q;
	logic [63:0] a_q, b_q, sum_q;
	logic        sx_q, sub_q, zsign_q;
	logic [11:0] ex_q, d_q, e_q;
	logic [52:0] mx_q, my_q;
	logic [55:0] s_q;

	// unpack and order by magnitude
	logic        a_nan, b_nan, a_inf, b_inf, swap;
	logic [63:0] big, lit, spec_val;
	logic        spec;
	logic [11:0] ebig, elit;

	always_comb begin
		a_nan = (a_q[62:52] == 11'h7FF) && (a_q[51:0] != 52'd0);
		b_nan = (b_q[62:52] == 11'h7FF) && (b_q[51:0] != 52'd0);
		a_inf = (a_q[62:52] == 11'h7FF) && (a_q[51:0] == 52'd0);
		b_inf = (b_q[62:52] == 11'h7FF) && (b_q[51:0] == 52'd0);
		spec = 1'b1;
		priority if (a_nan) begin
			spec_val = a_q | 64'h0008_0000_0000_0000;
		end else if (b_nan) begin
			spec_val = b_q | 64'h0008_0000_0000_0000;
		end else if (a_inf && b_inf && (a_q[63] != b_q[63])) begin
			spec_val = QNAN_VAL;
		end else if (a_inf) begin
			spec_val = a_q;
		end else if (b_inf) begin
			spec_val = b_q;
		end else begin
			spec = 1'b0;
			spec_val = 64'd0;
		end
		swap = b_q[62:0] > a_q[62:0];
		big = swap ? b_q : a_q;
		lit = swap ? a_q : b_q;
		ebig = {1'b0, big[62:52]} | {11'd0, big[62:52] == 11'd0};
		elit = {1'b0, lit[62:52]} | {11'd0, lit[62:52] == 11'd0};
	end

	// align smaller operand with sticky, then add or subtract
	logic [55:0] ext, shd, back;
	logic [5:0]  dd;
	logic [55:0] yal;
	logic [56:0] raw;

	always_comb begin
		ext  = {my_q, 3'b000};
		dd   = (d_q >= 12'd56) ? 6'd56 : d_q[5:0];
		shd  = ext >> dd;
		back = shd << dd;
		yal  = {shd[55:1], shd[0] | (back != ext)};
		raw  = sub_q ? ({1'b0, mx_q, 3'b000} - {1'b0, yal})
		             : ({1'b0, mx_q, 3'b000} + {1'b0, yal});
	end

	// round to nearest even and pack
	logic        inc;
	logic [53:0] m;
	logic [52:0] mf;
	logic [11:0] er;
	logic [63:0] packed_val;

	always_comb begin
		inc = s_q[2] & (s_q[1] | s_q[0] | s_q[3]);
		m   = {1'b0, s_q[55:3]} + {53'd0, inc};
		if (m[53]) begin
			mf = m[53:1];
			er = e_q + 12'd1;
		end else begin
			mf = m[52:0];
			er = e_q;
		end
		if (er >= 12'd2047) begin
			packed_val = {sx_q, 11'h7FF, 52'd0};
		end else begin
			packed_val = {sx_q, (mf[52] ? er[10:0] : 11'd0), mf[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			unique case (state_q)
				FS_IDLE, FS_DONE: begin
					if (start) begin
						a_q <= a;
						b_q <= b;
						state_q <= FS_ALIGN;
					end
				end
				FS_ALIGN: begin
					if (spec) begin
						sum_q <= spec_val;
						state_q <= FS_DONE;
					end else begin
						sx_q <= big[63];
						sub_q <= big[63] ^ lit[63];
						zsign_q <= a_q[63] & b_q[63];
						ex_q <= ebig;
						d_q <= ebig - elit;
						mx_q <= {big[62:52] != 11'd0, big[51:0]};
						my_q <= {lit[62:52] != 11'd0, lit[51:0]};
						state_q <= FS_SUM;
					end
				end
				FS_SUM: begin
					if (raw[56]) begin
						s_q <= {raw[56:2], raw[1] | raw[0]};
						e_q <= ex_q + 12'd1;
					end else begin
						s_q <= raw[55:0];
						e_q <= ex_q;
					end
					state_q <= FS_NORM;
				end
				FS_NORM: begin
					// shift left one bit a cycle until normal or subnormal floor
					if (s_q == 56'd0) begin
						sum_q <= {zsign_q, 63'd0};
						state_q <= FS_DONE;
					end else if (s_q[55] || (e_q == 12'd1)) begin
						state_q <= FS_ROUND;
					end else begin
						s_q <= {s_q[54:0], 1'b0};
						e_q <= e_q - 12'd1;
					end
				end
				FS_ROUND: begin
					sum_q <= packed_val;
					state_q <= FS_DONE;
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

	assign done = (state_q == FS_DONE);
	assign sum  = sum_q;

endmodule

[hw/rtl/srma_front.sv]
module srma_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [srma_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [srma_pkg::ROW_W-1:0]    row,
	input  logic [srma_pkg::COL_W-1:0]    col,
	input  logic [srma_pkg::VAL_W-1:0]    value,
	input  srma_pkg::srma_ctl_t           ctl,
	output logic                          q_valid,
	output srma_pkg::srma_item_t          q_head
);

	logic [srma_pkg::CFG_W-1:0] row_count_q, column_count_q;
	srma_pkg::srma_item_t       fifo_q [2];
	logic                       wr_ptr_q, rd_ptr_q;
	logic [1:0]                 count_q;
	srma_pkg::srma_item_t       cls;
	logic                       push, is_read, row_bad, col_bad;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			column_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srma_pkg::CFG_ROW_COUNT:    row_count_q <= cfg_data;
				srma_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify: errors and out-of-range reads resolve without the store
	always_comb begin
		is_read = cmd >= srma_pkg::CMD_READ;
		row_bad = {1'b0, row} >= row_count_q;
		col_bad = {1'b0, col} >= column_count_q;
		cls.cmd = cmd;
		cls.row = row;
		cls.col = col;
		cls.value = value;
		cls.direct = 1'b1;
		priority if (is_read && row_bad) begin
			cls.status = srma_pkg::STATUS_BOUNDS;
		end else if (is_read && col_bad) begin
			cls.status = srma_pkg::STATUS_OK;
		end else if (!is_read && (row_count_q == '0)) begin
			cls.status = srma_pkg::STATUS_UNSIZED;
		end else if (!is_read && (row_bad || col_bad)) begin
			cls.status = srma_pkg::STATUS_BOUNDS;
		end else begin
			cls.status = srma_pkg::STATUS_OK;
			cls.direct = 1'b0;
		end
	end

	assign in_stall = (count_q == 2'd2) || ctl.clearing;
	assign push     = in_valid && !in_stall;
	assign q_valid  = count_q != 2'd0;
	assign q_head   = fifo_q[rd_ptr_q];

	// two-entry queue toward the back end
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, ctl.pop};
		end
	end

endmodule

[hw/rtl/srma_back.sv]
module srma_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  srma_pkg::srma_item_t       q_head,
	output srma_pkg::srma_ctl_t        ctl,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [srma_pkg::VAL_W-1:0] result_value,
	output logic [srma_pkg::COL_W-1:0] slot,
	output logic                       newly_added,
	output logic [1:0]                 status
);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAP, S_VAL, S_ADD} bstate_t;

	localparam int CW = srma_pkg::COL_W;

	bstate_t                         state_q;
	srma_pkg::srma_item_t            cur_q;
	logic [srma_pkg::CELL_W-1:0]     clr_cnt_q;
	logic [CW-1:0]                   slot_q;
	logic                            out_valid_q, newly_q;
	logic [srma_pkg::VAL_W-1:0]      res_q;
	logic [CW-1:0]                   res_slot_q;
	logic [1:0]                      res_status_q;

	logic                            map_we, map_re, val_we, val_re;
	logic [srma_pkg::CELL_W-1:0]     map_waddr, map_raddr, val_waddr, val_raddr;
	logic [CW:0]                     map_wdata, map_rdata;
	logic [srma_pkg::VAL_W-1:0]      val_wdata, val_rdata, add_sum;
	logic                            fill_we, fill_re;
	logic [srma_pkg::ROW_W-1:0]      fill_waddr, fill_raddr;
	logic [srma_pkg::FILL_W-1:0]     fill_wdata;
	logic                            add_start, add_done;
	logic                            out_free, is_read, map_hit, fill_full, res_load;
	logic [srma_pkg::FILL_W-1:0]     fill;

	srma_ram #(.WIDTH(CW + 1), .DEPTH(srma_pkg::CELLS)) u_slot_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata)
	);

	srma_ram #(.WIDTH(srma_pkg::VAL_W), .DEPTH(srma_pkg::CELLS)) u_value_store (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.re(val_re), .raddr(val_raddr), .rdata(val_rdata)
	);

	srma_ram #(.WIDTH(srma_pkg::FILL_W), .DEPTH(srma_pkg::MAX_ROWS)) u_row_fill (
		.clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
		.re(fill_re), .raddr(fill_raddr), .rdata(fill)
	);

	srma_fadd u_fadd (
		.clk(clk), .arst_n(arst_n), .start(add_start), .a(val_rdata),
		.b(cur_q.value), .done(add_done), .sum(add_sum)
	);

	// drive memory ports and the queue pop from the current state
	always_comb begin
		out_free  = !out_valid_q || !out_stall;
		is_read   = cur_q.cmd >= srma_pkg::CMD_READ;
		map_hit   = map_rdata[CW];
		fill_full = fill[CW];
		map_we = 1'b0; map_waddr = '0; map_wdata = '0;
		map_re = 1'b0; map_raddr = '0;
		val_we = 1'b0; val_waddr = '0; val_wdata = '0;
		val_re = 1'b0; val_raddr = '0;
		fill_we = 1'b0; fill_waddr = '0; fill_wdata = '0;
		fill_re = 1'b0; fill_raddr = '0;
		add_start = 1'b0;
		res_load = 1'b0;
		ctl.pop = 1'b0;
		ctl.clearing = (state_q == S_CLEAR);
		unique case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				map_waddr = clr_cnt_q;
				fill_we = 1'b1;
				fill_waddr = clr_cnt_q[srma_pkg::ROW_W-1:0];
			end
			S_IDLE: begin
				if (q_valid) begin
					if (q_head.direct) begin
						ctl.pop = out_free;
						res_load = out_free;
					end else begin
						ctl.pop = 1'b1;
						map_re = 1'b1;
						map_raddr = {q_head.row, q_head.col};
						fill_re = 1'b1;
						fill_raddr = q_head.row;
					end
				end
			end
			S_MAP: begin
				res_load = !map_hit && out_free;
				if (map_hit) begin
					val_re = 1'b1;
					val_raddr = {cur_q.row, map_rdata[CW-1:0]};
				end else if (!is_read && !fill_full && out_free) begin
					val_we = 1'b1;
					val_waddr = {cur_q.row, fill[CW-1:0]};
					val_wdata = cur_q.value;
					map_we = 1'b1;
					map_waddr = {cur_q.row, cur_q.col};
					map_wdata = {1'b1, fill[CW-1:0]};
					fill_we = 1'b1;
					fill_waddr = cur_q.row;
					fill_wdata = fill + 1'b1;
				end
			end
			S_VAL: begin
				if ((cur_q.cmd == srma_pkg::CMD_INSERT) && out_free) begin
					val_we = 1'b1;
					val_waddr = {cur_q.row, slot_q};
					val_wdata = cur_q.value;
				end
				add_start = cur_q.cmd == srma_pkg::CMD_ADD;
				res_load = (cur_q.cmd != srma_pkg::CMD_ADD) && out_free;
			end
			S_ADD: begin
				if (add_done && out_free) begin
					val_we = 1'b1;
					val_waddr = {cur_q.row, slot_q};
					val_wdata = add_sum;
				end
				res_load = add_done && out_free;
			end
			default: ;
		endcase
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (ctl.pop) begin
						cur_q <= q_head;
						if (q_head.direct) begin
							res_q <= '0;
							res_slot_q <= '0;
							newly_q <= 1'b0;
							res_status_q <= q_head.status;
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					if (map_hit) begin
						slot_q <= map_rdata[CW-1:0];
						state_q <= S_VAL;
					end else if (out_free) begin
						res_q <= map_we ? cur_q.value : '0;
						res_slot_q <= map_we ? fill[CW-1:0] : '0;
						newly_q <= map_we;
						res_status_q <= (!is_read && fill_full) ? srma_pkg::STATUS_BOUNDS
						                                         : srma_pkg::STATUS_OK;
						state_q <= S_IDLE;
					end
				end
				S_VAL: begin
					if (cur_q.cmd == srma_pkg::CMD_ADD) begin
						state_q <= S_ADD;
					end else if (out_free) begin
						res_q <= is_read ? val_rdata : cur_q.value;
						res_slot_q <= slot_q;
						newly_q <= 1'b0;
						res_status_q <= srma_pkg::STATUS_OK;
						state_q <= S_IDLE;
					end
				end
				S_ADD: begin
					if (add_done && out_free) begin
						res_q <= add_sum;
						res_slot_q <= slot_q;
						newly_q <= 1'b0;
						res_status_q <= srma_pkg::STATUS_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q;
	assign slot         = res_slot_q;
	assign newly_added  = newly_q;
	assign status       = res_status_q;

endmodule

[hw/rtl/sparse_row_map_accumulator_unit.sv]
// channel | direction | handshake          | payload
// input   | in        | in_valid, in_stall | cmd, row, col, value
// output  | out       | out_valid,out_stall| result_value, slot, newly_added, status
// config  | in        | cfg_we             | cfg_index, cfg_data
//
// Items run one at a time through the back-end sequencer over the slot-map,
// row-fill and value RAMs: errors and out-of-range reads resolve from idle,
// other reads and writes go through the slot-map lookup and, on a hit, the
// value read, and an insert-add then waits for the adder (early for NaN or
// infinity; its normalize loop shifts left a bit at a time after cancellation).
// After reset a clearing pass writes all 4096 slot-map cells and 64 row fill
// counts, in_stall high. A two-entry queue holds items while the output stalls.
module sparse_row_map_accumulator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [srma_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [srma_pkg::ROW_W-1:0] row,
	input  logic [srma_pkg::COL_W-1:0] col,
	input  logic [srma_pkg::VAL_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [srma_pkg::VAL_W-1:0] result_value,
	output logic [srma_pkg::COL_W-1:0] slot,
	output logic                       newly_added,
	output logic [1:0]                 status
);

	srma_pkg::srma_ctl_t  ctl;
	srma_pkg::srma_item_t q_head;
	logic                 q_valid;

	srma_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.row(row), .col(col), .value(value), .ctl(ctl), .q_valid(q_valid),
		.q_head(q_head)
	);

	srma_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head), .ctl(ctl),
		.out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
		.slot(slot), .newly_added(newly_added), .status(status)
	);

	// no item enters while the slot map is being cleared
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> in_stall) else $error("item accepted during clearing");

	// a new entry is always a successful write
	a_new_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && newly_added) |-> (status == srma_pkg::STATUS_OK))
		else $error("new entry with error status");

	// errors carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != srma_pkg::STATUS_OK)) |->
		((result_value == '0) && (slot == '0) && !newly_added))
		else $error("error result with payload");

	// pop only from a non-empty queue
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> q_valid) else $error("pop from empty queue");

endmodule

[test/srma_checker.sv]
`timescale 1ns / 1ps

module srma_checker
	import srma_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	input  logic [VAL_W-1:0]    value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [VAL_W-1:0]    result_value,
	input  logic [COL_W-1:0]    slot,
	input  logic                newly_added,
	input  logic [1:0]          status,
	output int                  fails,
	output int                  pending
);

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [COL_W-1:0] slot;
		logic             added;
		logic [1:0]       status;
	} entry_result_t;

	// shadow copy of the block's storage
	logic [CFG_W-1:0]  row_limit;
	logic [CFG_W-1:0]  col_limit;
	logic              cell_valid [CELLS];
	logic [COL_W-1:0]  cell_slot [CELLS];
	logic [VAL_W-1:0]  slot_value [CELLS];
	logic [FILL_W-1:0] fill_count [MAX_ROWS];

	entry_result_t expected_results[$];

	function automatic logic is_nan(input logic [VAL_W-1:0] b);
		return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
	endfunction

	// apply one command to the shadow store and return its result
	function automatic entry_result_t apply_command(input logic [1:0] c,
			input logic [ROW_W-1:0] r, input logic [COL_W-1:0] k,
			input logic [VAL_W-1:0] v);
		entry_result_t res;
		int rows;
		int cols;
		logic [CELL_W-1:0] cell_idx;
		logic [CELL_W-1:0] vidx;
		res = '0;
		rows = (row_limit > MAX_ROWS) ? MAX_ROWS : int'(row_limit);
		cols = (col_limit > MAX_COLS) ? MAX_COLS : int'(col_limit);
		cell_idx = {r, k};
		if (c != CMD_INSERT && c != CMD_ADD) begin
			if (r >= rows) begin
				res.status = STATUS_BOUNDS;
			end else if (k < cols && cell_valid[cell_idx]) begin
				vidx = {r, cell_slot[cell_idx]};
				res.val = slot_value[vidx];
				res.slot = cell_slot[cell_idx];
			end
			return res;
		end
		if (row_limit == 0) begin
			res.status = STATUS_UNSIZED;
			return res;
		end
		if (r >= rows || k >= cols) begin
			res.status = STATUS_BOUNDS;
			return res;
		end
		if (cell_valid[cell_idx]) begin
			vidx = {r, cell_slot[cell_idx]};
			if (c == CMD_ADD)
				slot_value[vidx] = $realtobits($bitstoreal(slot_value[vidx]) + $bitstoreal(v));
			else
				slot_value[vidx] = v;
			res.val = slot_value[vidx];
			res.slot = cell_slot[cell_idx];
			return res;
		end
		// new entry takes the next free slot of its row
		vidx = {r, fill_count[r][COL_W-1:0]};
		slot_value[vidx] = v;
		cell_valid[cell_idx] = 1'b1;
		cell_slot[cell_idx] = fill_count[r][COL_W-1:0];
		fill_count[r] = fill_count[r] + 1'b1;
		res.val = v;
		res.slot = cell_slot[cell_idx];
		res.added = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		entry_result_t exp_res;
		logic val_ok;
		if (!arst_n) begin
			row_limit <= '0;
			col_limit <= '0;
			for (int i = 0; i < CELLS; i++) cell_valid[i] = 1'b0;
			for (int i = 0; i < MAX_ROWS; i++) fill_count[i] = '0;
			expected_results.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				if (cfg_index == CFG_ROW_COUNT) row_limit <= cfg_data;
				else col_limit <= cfg_data;
			end
			// predict each accepted item
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
					apply_command(cmd, row, col, value));
			// compare each accepted result with the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fails < 10)
						$display("checker: unexpected result value=%h slot=%0d new=%0d st=%0d",
							result_value, slot, newly_added, status);
					fails <= fails + 1;
				end else begin
					exp_res = expected_results.pop_front();
					// any NaN encoding is accepted where a NaN is predicted
					val_ok = (result_value === exp_res.val) ||
						(is_nan(exp_res.val) && is_nan(result_value));
					if (!val_ok || slot !== exp_res.slot ||
							newly_added !== exp_res.added || status !== exp_res.status) begin
						if (fails < 10)
							$display("checker: mismatch exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
								exp_res.val, exp_res.slot, exp_res.added, exp_res.status,
								result_value, slot, newly_added, status);
						fails <= fails + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

[test/tb_sparse_row_map_accumulator_unit.sv]
`timescale 1ns / 1ps

module tb_sparse_row_map_accumulator_unit;
	import srma_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = 1'b0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_INSERT;
	logic [ROW_W-1:0]   row = '0;
	logic [COL_W-1:0]   col = '0;
	logic [VAL_W-1:0]   value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [VAL_W-1:0]   result_value;
	logic [COL_W-1:0]   slot;
	logic               newly_added;
	logic [1:0]         status;

	int fails;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int rows_cfg = 0;
	int cols_cfg = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	sparse_row_map_accumulator_unit dut (.*);

	srma_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			hold_left <= 400;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input int data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ROW_COUNT) rows_cfg = data;
		else cols_cfg = data;
	endtask

	task automatic send_item(input logic [1:0] c, input int r, input int k,
			input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		row <= r[ROW_W-1:0];
		col <= k[COL_W-1:0];
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the input idle until every result is back, then let the adder settle
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55)
			return $realtobits(real'(int'($urandom_range(2000)) - 1000) / 8.0);
		if (sel < 80)
			return {$urandom(), $urandom()};
		case ($urandom_range(5))
			0: return 64'h7FF0_0000_0000_0000;
			1: return 64'hFFF0_0000_0000_0000;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h0000_0000_0000_0001;
			4: return 64'h7FEF_FFFF_FFFF_FFFF;
			default: return 64'h7FF8_0000_0000_0001;
		endcase
	endfunction

	// mostly in-bounds commands on a few hot cells, some fully random
	task automatic send_random(input int count);
		int r;
		int k;
		int sel;
		logic [1:0] c;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 85 && rows_cfg > 0 && cols_cfg > 0) begin
				r = (rows_cfg > 64) ? 64 : rows_cfg;
				k = (cols_cfg > 64) ? 64 : cols_cfg;
				r = ($urandom_range(99) < 70) ? $urandom_range(((r < 4) ? r : 4) - 1)
					: $urandom_range(r - 1);
				k = ($urandom_range(99) < 60) ? $urandom_range(((k < 6) ? k : 6) - 1)
					: $urandom_range(k - 1);
			end else begin
				r = $urandom_range(63);
				k = $urandom_range(63);
			end
			sel = $urandom_range(99);
			if (sel < 30) c = CMD_INSERT;
			else if (sel < 70) c = CMD_ADD;
			else if (sel < 95) c = CMD_READ;
			else c = 2'd3;
			send_item(c, r, k, pick_value());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unsized matrix: writes report not sized, reads out of bounds
		write_reg(CFG_ROW_COUNT, 0);
		write_reg(CFG_COLUMN_COUNT, 64);
		send_item(CMD_INSERT, 0, 0, 64'h3FF0_0000_0000_0000);
		send_item(CMD_ADD, 63, 63, 64'h3FF0_0000_0000_0000);
		send_item(CMD_READ, 0, 0, '0);
		send_item(2'd3, 63, 63, '1);
		send_random(60);
		drain();

		// full size, no idling, then a long output hold-off
		write_reg(CFG_ROW_COUNT, 64);
		send_item(CMD_INSERT, 0, 0, '1);
		send_item(CMD_INSERT, 63, 63, '0);
		send_item(CMD_ADD, 0, 0, 64'h3FF0_0000_0000_0000);
		send_item(CMD_READ, 0, 0, '0);
		send_item(CMD_READ, 63, 63, '0);
		send_item(CMD_READ, 5, 5, '0);
		send_item(CMD_ADD, 1, 2, 64'h7FF0_0000_0000_0000);
		send_item(CMD_ADD, 1, 2, 64'hFFF0_0000_0000_0000);
		send_item(CMD_READ, 1, 2, '0);
		send_item(2'd3, 63, 63, '0);
		send_item(CMD_INSERT, 63, 63, 64'h0000_0000_0000_0001);
		send_item(CMD_ADD, 63, 63, 64'h8000_0000_0000_0001);
		send_item(CMD_ADD, 63, 63, 64'hC000_0000_0000_0000);
		send_item(CMD_ADD, 63, 63, 64'h4000_0000_0000_0000);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		send_random(350);
		drain();

		// idle sender on the full matrix
		idle_pct = 71;
		send_random(300);
		drain();

		// small bounds, stalling receiver
		idle_pct = 0;
		stall_pct = 71;
		write_reg(CFG_ROW_COUNT, 3);
		write_reg(CFG_COLUMN_COUNT, 5);
		send_item(CMD_INSERT, 3, 0, 64'h4000_0000_0000_0000);
		send_item(CMD_ADD, 0, 5, 64'h4000_0000_0000_0000);
		send_item(CMD_READ, 3, 0, '0);
		send_item(CMD_READ, 0, 63, '0);
		send_item(CMD_READ, 1, 2, '0);
		send_random(250);
		drain();

		// register values past the limits, both sides idling
		idle_pct = 27;
		stall_pct = 27;
		write_reg(CFG_ROW_COUNT, 127);
		write_reg(CFG_COLUMN_COUNT, 127);
		send_random(300);
		drain();

		idle_pct = 0;
		stall_pct = 0;
		write_reg(CFG_ROW_COUNT, 1);
		write_reg(CFG_COLUMN_COUNT, 1);
		send_random(150);
		drain();

		// back to unsized with entries stored
		write_reg(CFG_ROW_COUNT, 0);
		send_random(60);
		drain();

		// stored entries reappear when the bounds grow back
		write_reg(CFG_ROW_COUNT, 64);
		write_reg(CFG_COLUMN_COUNT, 64);
		send_random(100);
		drain();

		if (fails == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sparse_row_map_accumulator_unit.f]
hw/rtl/srma_pkg.sv
hw/rtl/srma_ram.sv
hw/rtl/srma_fadd.sv
hw/rtl/srma_front.sv
hw/rtl/srma_back.sv
hw/rtl/sparse_row_map_accumulator_unit.sv
test/srma_checker.sv
test/tb_sparse_row_map_accumulator_unit.sv
